>>> hdl/rglb_pkg.sv
package rglb_pkg;

	localparam int DEF_MAX_RADIUS = 255;

	// decoupling queue between front and back, and the result queue
	localparam int MID_DEPTH = 16;
	localparam int OUT_DEPTH = 4;

	// registers between an accepted item and its push into the decoupling queue
	localparam int FRONT_LAT = 7;

	localparam int CFG_ADDR_W = 4;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_PIXEL = 1'b1;

	typedef enum logic [1:0] {
		REG_CENTER_X,
		REG_CENTER_Y,
		REG_MAX_RADIUS,
		REG_BYTE_SWAPPED
	} reg_idx_t;

	typedef struct packed {
		logic signed [12:0] center_x;
		logic signed [12:0] center_y;
		logic [7:0]         max_radius;
	} cfg_t;

	// en: store the word (table write) or look up a glow (pixel)
	typedef struct packed {
		logic        kind;
		logic        en;
		logic [11:0] addr;
		logic [15:0] data;
	} mid_item_t;

	typedef struct packed {
		logic [15:0] pixel;
		logic        applied;
	} out_item_t;

endpackage

>>> hdl/radial_glow_lut_blend_core.sv
// Radial glow blender for an RGB565 pixel stream.
// Input channel: push/full. kind 0 stores table_value at table_index of the glow
// table (16 dithered colors per radius); kind 1 blends under_pixel at (x_pos, y_pos)
// with the glow entry for its integer distance from the configured centre.
// Result channel: empty/pop. One result per pixel transaction, none per table
// write, in input order.
// Configuration: APB registers center_x (0x0), center_y (0x4), max_radius (0x8),
// byte_swapped (0xC); write them only while no transaction is in flight.
// Throughput: one transaction per cycle while full is low. The front is a 7-stage
// pipeline (offsets, squares, radius compare, 4-stage root unit) feeding a
// 16-entry queue; the back does one table RAM access per cycle, write or read,
// while the result side has room. A pixel passes the front stages, the decoupling
// queue, the lookup stage and the result queue on its way to the result ports.
// Reset clears the registers and all queues; the glow table is not cleared and
// must be loaded before any pixel reads it.
// When pop stays low, results collect in a 4-entry queue, the back stops
// draining the front queue, and full rises once it and the front stages hold 16 items.
module radial_glow_lut_blend_core #(
	parameter int MAX_RADIUS = rglb_pkg::DEF_MAX_RADIUS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [rglb_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	input  logic                            push,
	output logic                            full,
	input  logic                            kind,
	input  logic [11:0]                     table_index,
	input  logic [15:0]                     table_value,
	input  logic [10:0]                     x_pos,
	input  logic [10:0]                     y_pos,
	input  logic [15:0]                     under_pixel,
	output logic                            empty,
	input  logic                            pop,
	output logic [15:0]                     out_pixel,
	output logic                            glow_applied
);

	logic signed [12:0] center_x_q;
	logic signed [12:0] center_y_q;
	logic [7:0]         max_radius_q;
	logic               byte_swapped_q;
	logic               cfg_we;
	rglb_pkg::reg_idx_t reg_idx;
	rglb_pkg::cfg_t     cfg;

	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite && pready;
	assign reg_idx = rglb_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q     <= '0;
			center_y_q     <= '0;
			max_radius_q   <= '0;
			byte_swapped_q <= 1'b0;
		end else if (cfg_we) begin
			case (reg_idx)
				rglb_pkg::REG_CENTER_X:     center_x_q     <= pwdata[12:0];
				rglb_pkg::REG_CENTER_Y:     center_y_q     <= pwdata[12:0];
				rglb_pkg::REG_MAX_RADIUS:   max_radius_q   <= pwdata[7:0];
				rglb_pkg::REG_BYTE_SWAPPED: byte_swapped_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			rglb_pkg::REG_CENTER_X:     prdata = {19'd0, center_x_q};
			rglb_pkg::REG_CENTER_Y:     prdata = {19'd0, center_y_q};
			rglb_pkg::REG_MAX_RADIUS:   prdata = {24'd0, max_radius_q};
			rglb_pkg::REG_BYTE_SWAPPED: prdata = {31'd0, byte_swapped_q};
			default:                    prdata = '0;
		endcase
	end

	assign cfg.center_x   = center_x_q;
	assign cfg.center_y   = center_y_q;
	assign cfg.max_radius = max_radius_q;

	logic                               mid_push;
	logic                               mid_pop;
	logic                               mid_empty;
	rglb_pkg::mid_item_t                mid_in;
	logic [$bits(rglb_pkg::mid_item_t)-1:0] mid_head;

	rglb_front #(
		.MAX_RADIUS(MAX_RADIUS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.push       (push),
		.full       (full),
		.kind       (kind),
		.table_index(table_index),
		.table_value(table_value),
		.x_pos      (x_pos),
		.y_pos      (y_pos),
		.under_pixel(under_pixel),
		.mid_pop    (mid_pop),
		.mid_push   (mid_push),
		.mid_item   (mid_in)
	);

	rglb_fifo #(
		.WIDTH($bits(rglb_pkg::mid_item_t)),
		.DEPTH(rglb_pkg::MID_DEPTH)
	) u_mid_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (mid_push),
		.push_data(mid_in),
		.pop      (mid_pop),
		.pop_data (mid_head),
		.empty    (mid_empty)
	);

	rglb_back #(
		.MAX_RADIUS(MAX_RADIUS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_swapped(byte_swapped_q),
		.mid_empty   (mid_empty),
		.mid_item    (rglb_pkg::mid_item_t'(mid_head)),
		.mid_pop     (mid_pop),
		.pop         (pop),
		.empty       (empty),
		.out_pixel   (out_pixel),
		.glow_applied(glow_applied)
	);

	// the back never drains an empty decoupling queue
	a_mid_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		mid_pop |-> !mid_empty)
		else $error("decoupling queue popped while empty");

	// every accepted transaction reaches the decoupling queue after the front latency
	a_front_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |-> ##(rglb_pkg::FRONT_LAT) mid_push)
		else $error("accepted transaction missing at the decoupling queue");

endmodule

>>> hdl/rglb_ram.sv
module rglb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> hdl/rglb_fifo.sv
module rglb_fifo #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_ptr_q];
	assign do_pop   = pop && !empty;
	assign do_push  = push && (cnt_q != CW'(DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!do_push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> hdl/rglb_isqrt.sv
module rglb_isqrt #(
	parameter int SIDE_W = 30
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [15:0]       in_value,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [7:0]        out_root,
	output logic [SIDE_W-1:0] out_side
);

	// four stages, two root bits each
	logic              vld_q  [0:3];
	logic [SIDE_W-1:0] side_q [0:3];
	logic [7:0]        root_q [0:3];
	logic [9:0]        rem_q  [0:2];
	logic [15:0]       val_q  [0:2];
	logic [7:0]        nroot  [0:3];
	logic [9:0]        nrem   [0:2];

	function automatic logic [17:0] sqrt_step(logic [9:0] rem, logic [7:0] root,
		logic [1:0] pair);
		logic [11:0] cur;
		logic [11:0] trial;
		logic [17:0] res;
		cur   = {rem, pair};
		trial = {2'b00, root, 2'b01};
		if (cur >= trial) begin
			res = {10'(cur - trial), root[6:0], 1'b1};
		end else begin
			res = {cur[9:0], root[6:0], 1'b0};
		end
		return res;
	endfunction

	always_comb begin
		logic [17:0] t1;
		logic [17:0] t2;
		t1 = sqrt_step(10'd0, 8'd0, in_value[15:14]);
		t2 = sqrt_step(t1[17:8], t1[7:0], in_value[13:12]);
		nrem[0]  = t2[17:8];
		nroot[0] = t2[7:0];
		for (int k = 1; k < 3; k++) begin
			t1 = sqrt_step(rem_q[k-1], root_q[k-1], val_q[k-1][15-4*k -: 2]);
			t2 = sqrt_step(t1[17:8], t1[7:0], val_q[k-1][13-4*k -: 2]);
			nrem[k]  = t2[17:8];
			nroot[k] = t2[7:0];
		end
		t1 = sqrt_step(rem_q[2], root_q[2], val_q[2][3:2]);
		t2 = sqrt_step(t1[17:8], t1[7:0], val_q[2][1:0]);
		nroot[3] = t2[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 4; k++) begin
				vld_q[k] <= 1'b0;
			end
		end else begin
			vld_q[0] <= in_valid;
			for (int k = 1; k < 4; k++) begin
				vld_q[k] <= vld_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		side_q[0] <= in_side;
		val_q[0]  <= in_value;
		for (int k = 1; k < 4; k++) begin
			side_q[k] <= side_q[k-1];
		end
		for (int k = 1; k < 3; k++) begin
			val_q[k] <= val_q[k-1];
		end
		for (int k = 0; k < 3; k++) begin
			rem_q[k] <= nrem[k];
		end
		for (int k = 0; k < 4; k++) begin
			root_q[k] <= nroot[k];
		end
	end

	assign out_valid = vld_q[3];
	assign out_root  = root_q[3];
	assign out_side  = side_q[3];

endmodule

>>> hdl/rglb_front.sv
module rglb_front #(
	parameter int MAX_RADIUS = rglb_pkg::DEF_MAX_RADIUS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rglb_pkg::cfg_t      cfg,
	input  logic                push,
	output logic                full,
	input  logic                kind,
	input  logic [11:0]         table_index,
	input  logic [15:0]         table_value,
	input  logic [10:0]         x_pos,
	input  logic [10:0]         y_pos,
	input  logic [15:0]         under_pixel,
	input  logic                mid_pop,
	output logic                mid_push,
	output rglb_pkg::mid_item_t mid_item
);

	localparam int DEPTH = (MAX_RADIUS + 1) * 16;
	localparam int OCC_W = $clog2(rglb_pkg::MID_DEPTH + 1);

	logic             accept;
	logic [OCC_W-1:0] occ_q;

	// occupancy covers every item in the stages and in the decoupling queue
	assign accept = push && !full;
	assign full   = (occ_q == OCC_W'(rglb_pkg::MID_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (accept && !mid_pop) begin
			occ_q <= occ_q + 1'b1;
		end else if (!accept && mid_pop) begin
			occ_q <= occ_q - 1'b1;
		end
	end

	// stage 1: offsets from the centre, classify
	logic signed [13:0]  dx_c;
	logic signed [13:0]  dy_c;
	logic [7:0]          mr_c;
	rglb_pkg::mid_item_t side_c;

	assign dx_c = $signed({3'b000, x_pos}) - $signed({cfg.center_x[12], cfg.center_x});
	assign dy_c = $signed({3'b000, y_pos}) - $signed({cfg.center_y[12], cfg.center_y});

	always_comb begin
		mr_c = (32'(cfg.max_radius) > 32'(MAX_RADIUS)) ? 8'(MAX_RADIUS) : cfg.max_radius;
		side_c.kind = kind;
		if (kind == rglb_pkg::KIND_PIXEL) begin
			side_c.en   = 1'b0;
			side_c.addr = {8'd0, y_pos[1:0], x_pos[1:0]};
			side_c.data = under_pixel;
		end else begin
			side_c.en   = (32'(table_index) < 32'(DEPTH));
			side_c.addr = table_index;
			side_c.data = table_value;
		end
	end

	logic                vld_s1;
	logic signed [13:0]  dx_s1;
	logic signed [13:0]  dy_s1;
	logic [7:0]          mr_s1;
	rglb_pkg::mid_item_t side_s1;

	// stage 2: magnitudes and squares
	logic [13:0] adx_c;
	logic [13:0] ady_c;
	logic        near_c;

	assign adx_c  = dx_s1[13] ? 14'(-dx_s1) : 14'(dx_s1);
	assign ady_c  = dy_s1[13] ? 14'(-dy_s1) : 14'(dy_s1);
	assign near_c = (adx_c[13:8] == '0) && (ady_c[13:8] == '0);

	logic                vld_s2;
	logic [15:0]         sqx_s2;
	logic [15:0]         sqy_s2;
	logic [15:0]         mr2_s2;
	logic                mr_nz_s2;
	logic                near_s2;
	rglb_pkg::mid_item_t side_s2;

	// stage 3: radius compare
	logic [16:0] r2_c;
	logic        hit_c;

	assign r2_c  = 17'(sqx_s2) + 17'(sqy_s2);
	assign hit_c = (side_s2.kind == rglb_pkg::KIND_PIXEL) && near_s2 && mr_nz_s2 &&
		(r2_c <= 17'(mr2_s2));

	logic                vld_s3;
	logic [15:0]         val_s3;
	rglb_pkg::mid_item_t side3_c;
	rglb_pkg::mid_item_t side_s3;

	// a pixel carries its lookup decision in en
	always_comb begin
		side3_c = side_s2;
		if (side_s2.kind == rglb_pkg::KIND_PIXEL) begin
			side3_c.en = hit_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1    <= dx_c;
		dy_s1    <= dy_c;
		mr_s1    <= mr_c;
		side_s1  <= side_c;
		sqx_s2   <= 16'(adx_c[7:0]) * 16'(adx_c[7:0]);
		sqy_s2   <= 16'(ady_c[7:0]) * 16'(ady_c[7:0]);
		mr2_s2   <= 16'(mr_s1) * 16'(mr_s1);
		mr_nz_s2 <= (mr_s1 != '0);
		near_s2  <= near_c;
		side_s2  <= side_s1;
		// feed zero to the root unit when no lookup happens
		val_s3   <= hit_c ? r2_c[15:0] : 16'd0;
		side_s3  <= side3_c;
	end

	logic                              sq_valid;
	logic [7:0]                        sq_root;
	logic [$bits(rglb_pkg::mid_item_t)-1:0] sq_side;
	rglb_pkg::mid_item_t               side_out;

	rglb_isqrt #(
		.SIDE_W($bits(rglb_pkg::mid_item_t))
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s3),
		.in_value (val_s3),
		.in_side  (side_s3),
		.out_valid(sq_valid),
		.out_root (sq_root),
		.out_side (sq_side)
	);

	assign side_out = rglb_pkg::mid_item_t'(sq_side);
	assign mid_push = sq_valid;

	always_comb begin
		mid_item = side_out;
		if (side_out.kind == rglb_pkg::KIND_PIXEL) begin
			mid_item.addr = {sq_root, side_out.addr[3:0]};
		end
	end

endmodule

>>> hdl/rglb_back.sv
module rglb_back #(
	parameter int MAX_RADIUS = rglb_pkg::DEF_MAX_RADIUS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_swapped,
	input  logic                mid_empty,
	input  rglb_pkg::mid_item_t mid_item,
	output logic                mid_pop,
	input  logic                pop,
	output logic                empty,
	output logic [15:0]         out_pixel,
	output logic                glow_applied
);

	localparam int DEPTH  = (MAX_RADIUS + 1) * 16;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int OCC_W  = $clog2(rglb_pkg::OUT_DEPTH + 1);

	localparam logic [15:0] MASK_R = 16'hF800;
	localparam logic [15:0] MASK_G = 16'h07E0;
	localparam logic [15:0] MASK_B = 16'h001F;

	function automatic logic [15:0] swap16(logic [15:0] v);
		return {v[7:0], v[15:8]};
	endfunction

	function automatic logic [15:0] add_sat565(logic [15:0] a, logic [15:0] b);
		logic [16:0] r;
		logic [16:0] g;
		logic [16:0] bl;
		r  = 17'(a & MASK_R) + 17'(b & MASK_R);
		g  = 17'(a & MASK_G) + 17'(b & MASK_G);
		bl = 17'(a & MASK_B) + 17'(b & MASK_B);
		if (r > 17'(MASK_R)) r = 17'(MASK_R);
		if (g > 17'(MASK_G)) g = 17'(MASK_G);
		if (bl > 17'(MASK_B)) bl = 17'(MASK_B);
		return r[15:0] | g[15:0] | bl[15:0];
	endfunction

	logic             take_pix;
	logic             out_take;
	logic [OCC_W-1:0] occ_q;

	// occupancy covers the lookup stage and the result queue
	assign mid_pop  = !mid_empty && (occ_q != OCC_W'(rglb_pkg::OUT_DEPTH));
	assign take_pix = mid_pop && (mid_item.kind == rglb_pkg::KIND_PIXEL);
	assign out_take = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (take_pix && !out_take) begin
			occ_q <= occ_q + 1'b1;
		end else if (!take_pix && out_take) begin
			occ_q <= occ_q - 1'b1;
		end
	end

	logic        ram_we;
	logic [15:0] rd_data;

	assign ram_we = mid_pop && (mid_item.kind == rglb_pkg::KIND_WRITE) && mid_item.en;

	rglb_ram #(
		.WIDTH(16),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ADDR_W'(mid_item.addr)),
		.wdata(mid_item.data),
		.raddr(ADDR_W'(mid_item.addr)),
		.rdata(rd_data)
	);

	logic                vld_b1;
	rglb_pkg::mid_item_t item_b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_b1 <= 1'b0;
		end else begin
			vld_b1 <= take_pix;
		end
	end

	always_ff @(posedge clk) begin
		item_b1 <= mid_item;
	end

	logic [15:0]         glow;
	rglb_pkg::out_item_t blend;

	assign glow = item_b1.en ? rd_data : 16'd0;

	always_comb begin
		blend.pixel   = item_b1.data;
		blend.applied = 1'b0;
		if (glow != '0) begin
			blend.applied = 1'b1;
			if (item_b1.data == '0) begin
				blend.pixel = glow;
			end else if (byte_swapped) begin
				blend.pixel = swap16(add_sat565(swap16(item_b1.data), swap16(glow)));
			end else begin
				blend.pixel = add_sat565(item_b1.data, glow);
			end
		end
	end

	logic [$bits(rglb_pkg::out_item_t)-1:0] head;
	rglb_pkg::out_item_t               head_item;

	rglb_fifo #(
		.WIDTH($bits(rglb_pkg::out_item_t)),
		.DEPTH(rglb_pkg::OUT_DEPTH)
	) u_out_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (vld_b1),
		.push_data(blend),
		.pop      (pop),
		.pop_data (head),
		.empty    (empty)
	);

	assign head_item    = rglb_pkg::out_item_t'(head);
	assign out_pixel    = head_item.pixel;
	assign glow_applied = head_item.applied;

endmodule

>>> tb/radial_glow_lut_blend_core_tb.sv
module radial_glow_lut_blend_core_tb;

	localparam int CLK_HALF      = 6;
	localparam int TABLE_WORDS   = (rglb_pkg::DEF_MAX_RADIUS + 1) * 16;
	localparam int PRELOAD_WORDS = 64;
	localparam int SETTLE_CYCLES = rglb_pkg::FRONT_LAT + rglb_pkg::MID_DEPTH +
		rglb_pkg::OUT_DEPTH + 16;
	localparam int CYCLE_LIMIT   = 300000;
	localparam int PHASE_ITEMS   = 20;
	localparam int HOLD_CYCLES   = 250;

	typedef struct packed {
		logic        kind;
		logic [11:0] tidx;
		logic [15:0] tval;
		logic [10:0] x;
		logic [10:0] y;
		logic [15:0] under;
	} glow_req_t;

	typedef struct packed {
		logic signed [12:0] cx;
		logic signed [12:0] cy;
		logic [7:0]         mr;
		logic               sw;
	} glow_cfg_t;

	class glow_scoreboard;
		logic [15:0] glow_mem [TABLE_WORDS];
		bit          written [TABLE_WORDS];
		glow_cfg_t   cfg;
		rglb_pkg::out_item_t expected_px [$];
		int n_writes;
		int n_pixels;
		int n_applied;
		int n_checked;
		int n_mismatch;

		function new();
			cfg = '0;
			n_writes = 0;
			n_pixels = 0;
			n_applied = 0;
			n_checked = 0;
			n_mismatch = 0;
		endfunction

		function int unsigned floor_sqrt(longint unsigned v);
			int unsigned r;
			r = 0;
			while (longint'(r + 1) * longint'(r + 1) <= v)
				r++;
			return r;
		endfunction

		function logic [15:0] swap_bytes(logic [15:0] v);
			return {v[7:0], v[15:8]};
		endfunction

		function logic [15:0] sat_add_rgb565(logic [15:0] a, logic [15:0] b);
			logic [5:0] rs;
			logic [6:0] gs;
			logic [5:0] bs;
			rs = a[15:11] + b[15:11];
			gs = a[10:5] + b[10:5];
			bs = a[4:0] + b[4:0];
			if (rs > 6'd31) rs = 6'd31;
			if (gs > 7'd63) gs = 7'd63;
			if (bs > 6'd31) bs = 6'd31;
			return {rs[4:0], gs[5:0], bs[4:0]};
		endfunction

		// table word that a pixel reads, when it lies inside the lit radius
		function bit lookup_index(glow_req_t it, output logic [11:0] idx);
			longint      dx;
			longint      dy;
			longint      r2;
			int unsigned r;
			idx = '0;
			dx = longint'(it.x) - longint'(cfg.cx);
			dy = longint'(it.y) - longint'(cfg.cy);
			r2 = dx * dx + dy * dy;
			if (it.kind != rglb_pkg::KIND_PIXEL || cfg.mr == 0 ||
				r2 > longint'(cfg.mr) * longint'(cfg.mr))
				return 1'b0;
			r = floor_sqrt(r2);
			idx = {r[7:0], it.y[1:0], it.x[1:0]};
			return 1'b1;
		endfunction

		function bit needs_word(glow_req_t it, output logic [11:0] idx);
			bit hit;
			hit = lookup_index(it, idx);
			return hit && !written[idx];
		endfunction

		// table writes update the shadow table, pixels queue one expected result
		function void note(glow_req_t it);
			logic [11:0] idx;
			logic [15:0] glow;
			rglb_pkg::out_item_t e;
			if (it.kind == rglb_pkg::KIND_WRITE) begin
				glow_mem[it.tidx] = it.tval;
				written[it.tidx] = 1'b1;
				n_writes++;
			end else begin
				e.pixel = it.under;
				e.applied = 1'b0;
				if (lookup_index(it, idx)) begin
					glow = glow_mem[idx];
					if (glow != 16'h0000) begin
						e.applied = 1'b1;
						if (it.under == 16'h0000)
							e.pixel = glow;
						else if (cfg.sw)
							e.pixel = swap_bytes(sat_add_rgb565(swap_bytes(it.under),
								swap_bytes(glow)));
						else
							e.pixel = sat_add_rgb565(it.under, glow);
					end
				end
				if (e.applied)
					n_applied++;
				expected_px.push_back(e);
				n_pixels++;
			end
		endfunction

		function void check(logic [15:0] pix, logic app);
			rglb_pkg::out_item_t e;
			if (expected_px.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10)
					$display("unexpected result: out_pixel %h glow_applied %b", pix, app);
			end else begin
				e = expected_px.pop_front();
				n_checked++;
				if (pix !== e.pixel || app !== e.applied) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display("mismatch: expected out_pixel %h glow_applied %b, got %h %b",
							e.pixel, e.applied, pix, app);
				end
			end
		endfunction

		function int pending();
			return expected_px.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [rglb_pkg::CFG_ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        push = 1'b0;
	logic        full;
	logic        kind = 1'b0;
	logic [11:0] table_index = '0;
	logic [15:0] table_value = '0;
	logic [10:0] x_pos = '0;
	logic [10:0] y_pos = '0;
	logic [15:0] under_pixel = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic [15:0] out_pixel;
	logic        glow_applied;

	glow_scoreboard sb;

	int n_cycles = 0;
	int recv_tick = 0;
	int hold_left = 0;
	int hold_seen = 0;
	int hold_tag = 0;
	int burst_left = 0;
	int n_settings = 0;

	radial_glow_lut_blend_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.push(push),
		.full(full),
		.kind(kind),
		.table_index(table_index),
		.table_value(table_value),
		.x_pos(x_pos),
		.y_pos(y_pos),
		.under_pixel(under_pixel),
		.empty(empty),
		.pop(pop),
		.out_pixel(out_pixel),
		.glow_applied(glow_applied)
	);

	always begin
		clk = 1'b0;
		#CLK_HALF;
		clk = 1'b1;
		#CLK_HALF;
	end

	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", n_cycles);
			$display("status: fail");
			$finish;
		end
	end

	// result side: check each popped transaction, then pick the next pop
	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			sb.check(out_pixel, glow_applied);
		recv_tick++;
		if (hold_tag != hold_seen) begin
			hold_seen = hold_tag;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else begin
			case ((recv_tick / 48) % 4)
				0: pop <= 1'b1;
				1: pop <= 1'($urandom_range(0, 1));
				2: pop <= ($urandom_range(0, 3) == 0);
				default: pop <= ($urandom_range(0, 9) != 0);
			endcase
		end
	end

	function automatic glow_req_t rand_item(logic k);
		glow_req_t it;
		int span;
		int px;
		int py;
		it.kind = k;
		it.tidx = 12'($urandom);
		it.tval = ($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom);
		it.x = 11'($urandom);
		it.y = 11'($urandom);
		case ($urandom_range(0, 7))
			0: it.under = 16'h0000;
			1: it.under = 16'hFFFF;
			default: it.under = 16'($urandom);
		endcase
		// aim most pixels into the square around the centre
		if (k == rglb_pkg::KIND_PIXEL && sb.cfg.mr != 0 && $urandom_range(0, 3) != 0) begin
			span = int'(sb.cfg.mr) + 1;
			px = int'(sb.cfg.cx) + int'($urandom_range(0, 2 * span)) - span;
			py = int'(sb.cfg.cy) + int'($urandom_range(0, 2 * span)) - span;
			if (px < 0) px = 0;
			if (px > 2047) px = 2047;
			if (py < 0) py = 0;
			if (py > 2047) py = 2047;
			it.x = px[10:0];
			it.y = py[10:0];
		end
		return it;
	endfunction

	task automatic drive_item(glow_req_t it);
		push <= 1'b1;
		kind <= it.kind;
		table_index <= it.tidx;
		table_value <= it.tval;
		x_pos <= it.x;
		y_pos <= it.y;
		under_pixel <= it.under;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sb.note(it);
	endtask

	// a pixel that would read a word never loaded gets that word written first
	task automatic send_item(glow_req_t it);
		glow_req_t   w;
		logic [11:0] widx;
		if (sb.needs_word(it, widx)) begin
			w = rand_item(rglb_pkg::KIND_WRITE);
			w.tidx = widx;
			drive_item(w);
		end
		drive_item(it);
	endtask

	task automatic send_write(logic [11:0] idx, logic [15:0] val);
		glow_req_t it;
		it = rand_item(rglb_pkg::KIND_WRITE);
		it.tidx = idx;
		it.tval = val;
		send_item(it);
	endtask

	task automatic send_pixel(logic [10:0] x, logic [10:0] y, logic [15:0] under);
		glow_req_t it;
		it = rand_item(rglb_pkg::KIND_PIXEL);
		it.x = x;
		it.y = y;
		it.under = under;
		send_item(it);
	endtask

	// bursts of random length, random gaps in between
	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 16);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// drop push, wait for every result, then let trailing table writes drain
	task automatic settle();
		push <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(rglb_pkg::reg_idx_t r, logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_cfg(glow_cfg_t c);
		settle();
		apb_write(rglb_pkg::REG_CENTER_X, {19'b0, c.cx});
		apb_write(rglb_pkg::REG_CENTER_Y, {19'b0, c.cy});
		apb_write(rglb_pkg::REG_MAX_RADIUS, {24'b0, c.mr});
		apb_write(rglb_pkg::REG_BYTE_SWAPPED, {31'b0, c.sw});
		sb.cfg = c;
		n_settings++;
	endtask

	task automatic run_random(int n);
		for (int i = 0; i < n; i++) begin
			send_item(rand_item(($urandom_range(0, 9) < 2) ? rglb_pkg::KIND_WRITE
				: rglb_pkg::KIND_PIXEL));
			pace();
		end
	endtask

	initial begin
		glow_cfg_t phases [8];
		glow_cfg_t c;
		sb = new();
		phases[0] = '{cx: 13'sd64, cy: 13'sd64, mr: 8'd255, sw: 1'b0};
		phases[1] = '{cx: -13'sd2048, cy: 13'sd4095, mr: 8'd255, sw: 1'b1};
		phases[2] = '{cx: 13'sd4095, cy: -13'sd2048, mr: 8'd1, sw: 1'b0};
		phases[3] = '{cx: 13'sd1024, cy: 13'sd700, mr: 8'd40, sw: 1'b1};
		phases[4] = '{cx: 13'sd0, cy: 13'sd0, mr: 8'd0, sw: 1'b1};
		phases[5] = '{cx: 13'sd2047, cy: 13'sd2047, mr: 8'd200, sw: 1'b1};
		phases[6] = '{cx: 13'sd0, cy: 13'sd2047, mr: 8'd1, sw: 1'b0};
		phases[7] = '{cx: 13'sd300, cy: 13'sd5, mr: 8'd128, sw: 1'b1};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// out of reset max_radius is 0, so pixels pass through untouched
		send_pixel(11'd0, 11'd0, 16'hFFFF);
		send_pixel(11'd2047, 11'd2047, 16'h0000);

		// load the innermost radii, with random gaps between the writes
		for (int i = 0; i < PRELOAD_WORDS; i++) begin
			send_write(12'(i), ($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom));
			pace();
		end

		apply_cfg(phases[0]);
		send_write(12'd0, 16'h0000);
		send_pixel(11'd64, 11'd64, 16'h1234);
		send_write(12'd0, 16'hFFFF);
		send_pixel(11'd64, 11'd64, 16'h1234);
		send_pixel(11'd64, 11'd64, 16'h0000);
		send_write(12'd17, 16'h0821);
		send_pixel(11'd65, 11'd64, 16'h8410);
		send_write(12'd4083, 16'hF81F);
		send_pixel(11'd319, 11'd64, 16'h4208);
		send_pixel(11'd319, 11'd65, 16'h4208);
		send_pixel(11'd0, 11'd0, 16'hFFFF);
		send_pixel(11'd2047, 11'd2047, 16'h7BEF);
		send_pixel(11'd2047, 11'd0, 16'h0001);
		send_write(12'd4095, 16'hFFFF);
		send_write(12'd4095, 16'h0000);

		for (int p = 0; p < 10; p++) begin
			if (p < 8) begin
				c = phases[p];
			end else begin
				c.cx = 13'(int'($urandom_range(0, 2400)) - 200);
				c.cy = 13'(int'($urandom_range(0, 2400)) - 200);
				c.mr = 8'($urandom);
				c.sw = 1'($urandom);
			end
			apply_cfg(c);
			// stall the result side for a long stretch while items keep coming
			if (p == 0 || p == 3) begin
				hold_tag <= hold_tag + 1;
				run_random(2 * PHASE_ITEMS);
			end else begin
				run_random(PHASE_ITEMS);
			end
		end

		settle();
		$display("ran %0d table writes and %0d pixels over %0d register settings",
			sb.n_writes, sb.n_pixels, n_settings);
		$display("%0d results checked, %0d with glow applied, %0d mismatches",
			sb.n_checked, sb.n_applied, sb.n_mismatch);
		if (sb.n_mismatch == 0 && sb.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
